>>> hdl/smst_pkg.sv
// Shared types, codes and sizing constants for the subset-match set table.
package smst_pkg;

  // Default sizing, handed to the top level parameters
  localparam int DEF_MAX_SETS  = 16;
  localparam int DEF_MAX_WORDS = 4;
  localparam int DEF_WORD_BITS = 32;

  // Fixed field widths
  localparam int CFG_W    = 3;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 3;
  localparam int HELD_W   = 5;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 8;

  localparam logic [CFG_W-1:0] WORDS_IN_USE_RST = 3'd4;

  // Slots in the front-to-back queue
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_FULL     = 3'd1,
    ST_LEN_ERR  = 3'd2,
    ST_QUERY    = 3'd3,
    ST_CLEARED  = 3'd4
  } status_t;

  // Classification of one word, passed from front to back
  typedef struct packed {
    op_t  op;
    logic last;
    logic len_err;
  } cmd_t;

  localparam int CMD_W = $bits(cmd_t);

endpackage

>>> hdl/smst_front.sv
// Front end: accepts words, tracks the run position and classifies each word.
module smst_front #(
  parameter int MAX_WORDS = 4,
  parameter int WORD_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [smst_pkg::CFG_W-1:0]   words_in_use,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [smst_pkg::OP_W-1:0]    op_in,
  input  logic [smst_pkg::IN_DATA_W-1:0] word_in,
  input  logic                         last_in,
  input  logic                         q_full,
  output logic                         push,
  output smst_pkg::cmd_t               cmd,
  output logic [$clog2(MAX_WORDS+2)-1:0] pos,
  output logic [WORD_BITS-1:0]         word
);
  import smst_pkg::*;

  localparam int POS_W = $clog2(MAX_WORDS + 2);
  localparam int LEN_W = ((CFG_W > POS_W) ? CFG_W : POS_W) + 1;

  logic [POS_W-1:0] word_position;
  logic [POS_W-1:0] word_position_next;
  logic             accept;
  logic             len_ok;

  // Length check against the configured word count
  always_comb begin
    len_ok = (words_in_use != '0) &&
             (LEN_W'(words_in_use) <= LEN_W'(MAX_WORDS)) &&
             ((LEN_W'(word_position) + LEN_W'(1)) == LEN_W'(words_in_use));
  end

  // Classify and forward the accepted word
  always_comb begin
    s_tready           = !q_full;
    accept             = s_tvalid && s_tready;
    push               = 1'b0;
    word_position_next = word_position;
    cmd.op             = op_t'(op_in);
    cmd.last           = last_in;
    cmd.len_err        = !len_ok;
    pos                = word_position;
    word               = WORD_BITS'(word_in);
    if (accept) begin
      case (op_in)
        OP_CLEAR: begin
          push               = 1'b1;
          word_position_next = '0;
        end
        OP_INSERT, OP_QUERY: begin
          push = 1'b1;
          if (last_in) begin
            word_position_next = '0;
          end else if (word_position <= POS_W'(MAX_WORDS)) begin
            word_position_next = word_position + POS_W'(1);
          end
        end
        default: begin
          // unused operation code: dropped without effect
          push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_position <= '0;
    end else begin
      word_position <= word_position_next;
    end
  end

endmodule

>>> hdl/smst_queue.sv
// Small flop-based FIFO between the front end and the back end.
module smst_queue #(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] din,
  output logic              full,
  input  logic              pop,
  output logic              valid,
  output logic [DATA_W-1:0] dout
);
  import smst_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [DATA_W-1:0] slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  fill;
  logic              do_push;
  logic              do_pop;

  always_comb begin
    full    = (fill == CNT_W'(QUEUE_DEPTH));
    valid   = (fill != '0);
    dout    = slots[rd_ptr];
    do_push = push && !full;
    do_pop  = pop && valid;
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + CNT_W'(1);
        2'b01:   fill <= fill - CNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

  // Slot storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

endmodule

>>> hdl/smst_back.sv
// Back end: set storage, query buffer, subset scan and the result register.
module smst_back #(
  parameter int MAX_SETS  = 16,
  parameter int MAX_WORDS = 4,
  parameter int WORD_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [smst_pkg::CFG_W-1:0]      words_in_use,
  input  logic                            q_valid,
  output logic                            pop,
  input  smst_pkg::cmd_t                  cmd,
  input  logic [$clog2(MAX_WORDS+2)-1:0]  pos,
  input  logic [WORD_BITS-1:0]            word,
  output logic                            out_valid,
  input  logic                            out_ready,
  output smst_pkg::status_t               out_status,
  output logic                            out_match,
  output logic [smst_pkg::HELD_W-1:0]     out_held,
  output logic [$clog2(MAX_SETS+1)-1:0]   held
);
  import smst_pkg::*;

  localparam int CNT_W  = $clog2(MAX_SETS + 1);
  localparam int POS_W  = $clog2(MAX_WORDS + 2);
  localparam int WIDX_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int DEPTH  = MAX_SETS * MAX_WORDS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LEN_W  = ((CFG_W > WIDX_W) ? CFG_W : WIDX_W) + 1;

  typedef enum logic [1:0] {
    BK_IDLE = 2'b01,
    BK_SCAN = 2'b10
  } bk_state_t;

  bk_state_t         state;
  logic [CNT_W-1:0]  set_count;
  logic [WORD_BITS-1:0] stored_sets [DEPTH];
  logic [WORD_BITS-1:0] query_words [MAX_WORDS];

  // scan issue side
  logic              issuing;
  logic [CNT_W-1:0]  scan_set;
  logic [WIDX_W-1:0] scan_word;
  logic [ADDR_W-1:0] scan_base;
  logic              word_end;
  logic              set_end;
  // scan compare side
  logic              rd_v;
  logic [WORD_BITS-1:0] rd_data;
  logic [WIDX_W-1:0] rd_word;
  logic              rd_end;
  logic              rd_final;
  logic              set_ok;
  logic              match_acc;
  logic              word_fail;
  logic              hit;

  logic              out_free;
  logic              pos_in_range;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;

  // Pop control and write decode
  always_comb begin
    out_free     = !out_valid || out_ready;
    pop          = q_valid && (state == BK_IDLE) && out_free;
    pos_in_range = (pos < POS_W'(MAX_WORDS));
    mem_we       = pop && (cmd.op == OP_INSERT) && pos_in_range &&
                   (set_count < CNT_W'(MAX_SETS));
    mem_waddr    = ADDR_W'(set_count) * ADDR_W'(MAX_WORDS) + ADDR_W'(pos);
    held         = set_count;
  end

  // Scan position decode and word compare
  always_comb begin
    word_end  = (LEN_W'(scan_word) + LEN_W'(1)) == LEN_W'(words_in_use);
    set_end   = (scan_set + CNT_W'(1)) == set_count;
    word_fail = |(rd_data & ~query_words[rd_word]);
    hit       = set_ok && !word_fail;
  end

  // Set storage: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      stored_sets[mem_waddr] <= word;
    end
    rd_data <= stored_sets[scan_base + ADDR_W'(scan_word)];
  end

  // Query word buffer
  always_ff @(posedge clk) begin
    if (pop && (cmd.op == OP_QUERY) && pos_in_range) begin
      query_words[pos[WIDX_W-1:0]] <= word;
    end
  end

  // Control, scan sequencing and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      set_count <= '0;
      out_valid <= 1'b0;
      issuing   <= 1'b0;
      rd_v      <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      rd_v <= 1'b0;
      case (state)
        BK_IDLE: begin
          if (pop) begin
            case (cmd.op)
              OP_CLEAR: begin
                set_count  <= '0;
                out_valid  <= 1'b1;
                out_status <= ST_CLEARED;
                out_match  <= 1'b0;
                out_held   <= '0;
              end
              OP_INSERT: begin
                if (cmd.last) begin
                  out_valid <= 1'b1;
                  out_match <= 1'b0;
                  out_held  <= HELD_W'(set_count);
                  if (cmd.len_err) begin
                    out_status <= ST_LEN_ERR;
                  end else if (set_count >= CNT_W'(MAX_SETS)) begin
                    out_status <= ST_FULL;
                  end else begin
                    out_status <= ST_INSERTED;
                    set_count  <= set_count + CNT_W'(1);
                    out_held   <= HELD_W'(set_count + CNT_W'(1));
                  end
                end
              end
              OP_QUERY: begin
                if (cmd.last) begin
                  if (cmd.len_err) begin
                    out_valid  <= 1'b1;
                    out_status <= ST_LEN_ERR;
                    out_match  <= 1'b0;
                    out_held   <= HELD_W'(set_count);
                  end else if (set_count == '0) begin
                    out_valid  <= 1'b1;
                    out_status <= ST_QUERY;
                    out_match  <= 1'b0;
                    out_held   <= '0;
                  end else begin
                    state     <= BK_SCAN;
                    issuing   <= 1'b1;
                    scan_set  <= '0;
                    scan_word <= '0;
                    scan_base <= '0;
                    set_ok    <= 1'b1;
                    match_acc <= 1'b0;
                  end
                end
              end
              default: begin
                state <= BK_IDLE;
              end
            endcase
          end
        end
        BK_SCAN: begin
          // issue one stored word per cycle
          if (issuing) begin
            rd_v     <= 1'b1;
            rd_word  <= scan_word;
            rd_end   <= word_end;
            rd_final <= word_end && set_end;
            if (word_end) begin
              scan_word <= '0;
              scan_set  <= scan_set + CNT_W'(1);
              scan_base <= scan_base + ADDR_W'(MAX_WORDS);
              if (set_end) begin
                issuing <= 1'b0;
              end
            end else begin
              scan_word <= scan_word + WIDX_W'(1);
            end
          end
          // compare the word read in the previous cycle
          if (rd_v) begin
            if (rd_end) begin
              set_ok    <= 1'b1;
              match_acc <= match_acc || hit;
            end else begin
              set_ok <= hit;
            end
            if (rd_final) begin
              state      <= BK_IDLE;
              out_valid  <= 1'b1;
              out_status <= ST_QUERY;
              out_match  <= match_acc || hit;
              out_held   <= HELD_W'(set_count);
            end
          end
        end
        default: begin
          state <= BK_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hdl/subset_match_set_table.sv
// Top level of the subset-match set table: config register, front, queue, back.
//
//  port group | dir | fields (low bit first)
//  -----------+-----+-----------------------------------------------
//  s_*        | in  | tuser: operation; tdata: data_word; tlast: last_word
//  m_*        | out | tuser: status; tdata: match_found, entries_held
//  cfg_*      | in  | cfg_data: words_in_use, written when cfg_we is high
//
// A word that is not the final word of a query run, and every insert or
// clear, is taken by the back end without a scan. A final query word of the
// right length against a non-empty table scans the table one stored word per
// cycle through the single read port of the set memory. The front end keeps
// accepting words into a two-entry queue while the back end scans.
// rst is synchronous; it empties the table and the queue and sets
// words_in_use to 4. A stalled result holds in the output register and
// stops the back end; the input stalls once the queue is full.
module subset_match_set_table #(
  parameter int MAX_SETS  = smst_pkg::DEF_MAX_SETS,
  parameter int MAX_WORDS = smst_pkg::DEF_MAX_WORDS,
  parameter int WORD_BITS = smst_pkg::DEF_WORD_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [smst_pkg::CFG_W-1:0]        cfg_data,   // words_in_use
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [smst_pkg::IN_DATA_W-1:0]    s_tdata,    // data_word
  input  logic [smst_pkg::OP_W-1:0]         s_tuser,    // operation
  input  logic                              s_tlast,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [smst_pkg::OUT_DATA_W-1:0]   m_tdata,    // match_found, entries_held, pad
  output logic [smst_pkg::STATUS_W-1:0]     m_tuser     // status
);
  import smst_pkg::*;

  localparam int POS_W  = $clog2(MAX_WORDS + 2);
  localparam int CNT_W  = $clog2(MAX_SETS + 1);
  localparam int Q_W    = CMD_W + POS_W + WORD_BITS;

  logic [CFG_W-1:0]     words_in_use;
  logic                 q_full;
  logic                 q_valid;
  logic                 push;
  logic                 pop;
  cmd_t                 f_cmd;
  logic [POS_W-1:0]     f_pos;
  logic [WORD_BITS-1:0] f_word;
  logic [Q_W-1:0]       q_din;
  logic [Q_W-1:0]       q_dout;
  cmd_t                 b_cmd;
  logic [POS_W-1:0]     b_pos;
  logic [WORD_BITS-1:0] b_word;
  status_t              out_status;
  logic                 out_match;
  logic [HELD_W-1:0]    out_held;
  logic [CNT_W-1:0]     held;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      words_in_use <= WORDS_IN_USE_RST;
    end else if (cfg_we) begin
      words_in_use <= cfg_data;
    end
  end

  smst_front #(
    .MAX_WORDS (MAX_WORDS),
    .WORD_BITS (WORD_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .words_in_use (words_in_use),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .op_in        (s_tuser),
    .word_in      (s_tdata),
    .last_in      (s_tlast),
    .q_full       (q_full),
    .push         (push),
    .cmd          (f_cmd),
    .pos          (f_pos),
    .word         (f_word)
  );

  // Queue entry packing
  always_comb begin
    q_din  = {f_cmd, f_pos, f_word};
    b_cmd  = cmd_t'(q_dout[Q_W-1 -: CMD_W]);
    b_pos  = q_dout[WORD_BITS +: POS_W];
    b_word = q_dout[WORD_BITS-1:0];
  end

  smst_queue #(
    .DATA_W (Q_W)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (q_din),
    .full  (q_full),
    .pop   (pop),
    .valid (q_valid),
    .dout  (q_dout)
  );

  smst_back #(
    .MAX_SETS  (MAX_SETS),
    .MAX_WORDS (MAX_WORDS),
    .WORD_BITS (WORD_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .words_in_use (words_in_use),
    .q_valid      (q_valid),
    .pop          (pop),
    .cmd          (b_cmd),
    .pos          (b_pos),
    .word         (b_word),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_status   (out_status),
    .out_match    (out_match),
    .out_held     (out_held),
    .held         (held)
  );

  // Result packing
  always_comb begin
    m_tuser = out_status;
    m_tdata = {(OUT_DATA_W - HELD_W - 1)'(0), out_held, out_match};
  end

  // Table count never passes its capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    held <= CNT_W'(MAX_SETS))
    else $error("set count exceeds table capacity");

  // Only a completed query can report a match
  a_match_query: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (out_status != ST_QUERY)) |-> !out_match)
    else $error("match flagged on a non-query result");

  // A clear result always reports an empty table
  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (out_status == ST_CLEARED)) |-> (out_held == '0))
    else $error("clear result with nonzero count");

  // The front end never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !push)
    else $error("push into full queue");

endmodule

>>> tb/subset_table_checker.sv
`timescale 1ns / 1ps
// Checker for the subset-match set table: watches both streams, predicts and compares results.
module subset_table_checker #(
  parameter int MAX_SETS  = smst_pkg::DEF_MAX_SETS,
  parameter int MAX_WORDS = smst_pkg::DEF_MAX_WORDS,
  parameter int WORD_BITS = smst_pkg::DEF_WORD_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [smst_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [smst_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic [smst_pkg::OP_W-1:0]       s_tuser,
  input  logic                            s_tlast,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [smst_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic [smst_pkg::STATUS_W-1:0]   m_tuser,
  output int                              mismatches,
  output int                              pending
);
  import smst_pkg::*;

  typedef struct packed {
    status_t           status;
    logic              match;
    logic [HELD_W-1:0] held;
  } answer_t;

  // Predicted contents of the block
  logic [WORD_BITS-1:0] set_words [MAX_SETS][MAX_WORDS];
  logic [WORD_BITS-1:0] query_buf [MAX_WORDS];
  int unsigned          held_sets;
  int unsigned          run_pos;
  logic [CFG_W-1:0]     words_in_use;

  // Answers still owed by the block, oldest first
  answer_t owed_answers [$];

  task automatic note_mismatch(input string what, input int want, input int got);
    mismatches++;
    $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
  endtask

  // Is any held set contained in the query buffer?
  function automatic logic subset_hit();
    logic hit;
    logic all_in;
    hit = 1'b0;
    for (int s = 0; s < held_sets; s++) begin
      all_in = 1'b1;
      for (int w = 0; w < words_in_use; w++)
        if ((set_words[s][w] & query_buf[w]) != set_words[s][w]) all_in = 1'b0;
      if (all_in) hit = 1'b1;
    end
    return hit;
  endfunction

  // Applies one accepted item; returns 1 when it yields an answer
  function automatic bit table_step(input logic [OP_W-1:0] op,
                                    input logic [IN_DATA_W-1:0] word,
                                    input logic last, output answer_t ans);
    int unsigned pos;
    int unsigned len;
    ans = '0;
    pos = run_pos;
    if (op != OP_INSERT && op != OP_QUERY && op != OP_CLEAR) return 1'b0;
    if (op == OP_CLEAR) begin
      held_sets = 0;
      run_pos = 0;
      ans.status = ST_CLEARED;
      return 1'b1;
    end
    // each word lands where its own operation sends it
    if (pos < MAX_WORDS) begin
      if (op == OP_QUERY) query_buf[pos] = word[WORD_BITS-1:0];
      else if (held_sets < MAX_SETS) set_words[held_sets][pos] = word[WORD_BITS-1:0];
    end
    if (!last) begin
      if (run_pos <= MAX_WORDS) run_pos++;
      return 1'b0;
    end
    len = pos + 1;
    run_pos = 0;
    if (words_in_use == 0 || words_in_use > MAX_WORDS || len != words_in_use) begin
      ans.status = ST_LEN_ERR;
    end else if (op == OP_QUERY) begin
      ans.status = ST_QUERY;
      ans.match = subset_hit();
    end else if (held_sets >= MAX_SETS) begin
      ans.status = ST_FULL;
    end else begin
      held_sets++;
      ans.status = ST_INSERTED;
    end
    ans.held = HELD_W'(held_sets);
    return 1'b1;
  endfunction

  // Output side first, so a result never matches an item taken at the same edge
  always @(posedge clk) begin : watch
    answer_t got;
    answer_t want;
    answer_t ans;
    if (rst) begin
      held_sets = 0;
      run_pos = 0;
      words_in_use = WORDS_IN_USE_RST;
      mismatches = 0;
      owed_answers.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.status = status_t'(m_tuser);
        got.match = m_tdata[0];
        got.held = m_tdata[HELD_W:1];
        if (owed_answers.size() == 0) begin
          note_mismatch("unexpected result, status", -1, int'(got.status));
        end else begin
          want = owed_answers.pop_front();
          if (got.status != want.status)
            note_mismatch("status", int'(want.status), int'(got.status));
          if (got.match != want.match)
            note_mismatch("match_found", int'(want.match), int'(got.match));
          if (got.held != want.held)
            note_mismatch("entries_held", int'(want.held), int'(got.held));
          if (m_tdata[OUT_DATA_W-1:HELD_W+1] != '0)
            note_mismatch("tdata pad", 0, int'(m_tdata[OUT_DATA_W-1:HELD_W+1]));
        end
      end
      // an item taken at the write edge still sees the old word count
      if (s_tvalid && s_tready)
        if (table_step(s_tuser, s_tdata, s_tlast, ans)) owed_answers.push_back(ans);
      if (cfg_we) words_in_use = cfg_data;
    end
    pending <= owed_answers.size();
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Testbench top for the subset-match set table: clock, reset, stimulus and verdict.
module testbench;
  import smst_pkg::*;

  localparam int MAX_SETS  = DEF_MAX_SETS;
  localparam int MAX_WORDS = DEF_MAX_WORDS;
  localparam int WORD_BITS = DEF_WORD_BITS;

  localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;  // unused code, block drops it

  // Worst run is about 1400 items, each with a gap, a full scan and a stall
  localparam int RUN_LIMIT    = 1_000_000;
  localparam int DRAIN_CYCLES = 100;   // longest scan reads all 16 * 4 stored words
  localparam int HOLD_CYCLES  = 300;   // long receiver stall
  localparam int PHASES       = 7;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_W-1:0]      cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;    // data_word
  logic [OP_W-1:0]       s_tuser = '0;    // operation
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;         // match_found, entries_held, pad
  logic [STATUS_W-1:0]   m_tuser;         // status

  int mismatches;
  int pending;
  int unsigned cycle_cnt = 0;

  // Write tracking so no run reads a word that was never written
  logic [MAX_WORDS-1:0] slot_written [MAX_SETS] = '{default: '0};
  logic [MAX_WORDS-1:0] query_written = '0;
  int                   gen_count = 0;
  int                   gen_pos = 0;
  logic [CFG_W-1:0]     run_words = WORDS_IN_USE_RST;

  bit tx_eager = 1'b0;
  bit rx_eager = 1'b0;
  bit hold_request = 1'b0;

  subset_match_set_table #(
    .MAX_SETS (MAX_SETS),
    .MAX_WORDS(MAX_WORDS),
    .WORD_BITS(WORD_BITS)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  subset_table_checker #(
    .MAX_SETS (MAX_SETS),
    .MAX_WORDS(MAX_WORDS),
    .WORD_BITS(WORD_BITS)
  ) u_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .mismatches(mismatches),
    .pending   (pending)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Timeout
  initial begin
    while (cycle_cnt < RUN_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Result receiver: random stalls, bursts of full rate, one long hold-off
  initial begin : receiver
    int gap;
    wait (rst == 1'b0);
    forever begin
      if (hold_request) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end
      if ($urandom_range(0, 39) == 0) rx_eager = !rx_eager;
      gap = rx_eager ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
    end
  end

  function automatic bit words_legal();
    return run_words >= 1 && run_words <= MAX_WORDS;
  endfunction

  // Sparse to full words for stored sets
  function automatic logic [31:0] set_word();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return $urandom & $urandom & $urandom;
      2: return $urandom;
      default: return '1;
    endcase
  endfunction

  // Mostly dense query words, so that matches and misses both occur
  function automatic logic [31:0] query_word();
    case ($urandom_range(0, 7))
      0, 1: return '1;
      2, 3, 4: return $urandom | $urandom | $urandom;
      5, 6: return $urandom;
      default: return '0;
    endcase
  endfunction

  // Offers one item and tracks which stored words it writes
  task automatic send_word(input logic [OP_W-1:0] op, input logic [31:0] word,
                           input logic last);
    int gap;
    if ($urandom_range(0, 39) == 0) tx_eager = !tx_eager;
    gap = tx_eager ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= word;
    s_tlast <= last;
    do @(posedge clk); while (!(s_tvalid && s_tready));
    if (op == OP_CLEAR) begin
      gen_count = 0;
      gen_pos = 0;
    end else if (op == OP_INSERT || op == OP_QUERY) begin
      if (gen_pos < MAX_WORDS) begin
        if (op == OP_QUERY) query_written[gen_pos] = 1'b1;
        else if (gen_count < MAX_SETS) slot_written[gen_count][gen_pos] = 1'b1;
      end
      if (!last) begin
        if (gen_pos <= MAX_WORDS) gen_pos++;
      end else begin
        if (op == OP_INSERT && words_legal() && gen_pos + 1 == run_words &&
            gen_count < MAX_SETS)
          gen_count++;
        gen_pos = 0;
      end
    end
  endtask

  // One run of words; in a mixed run of the right length the other operation is
  // used only where the word it leaves out was written earlier
  task automatic send_run(input logic [OP_W-1:0] last_op, input int len, input bit mixed);
    logic [OP_W-1:0] op;
    logic [OP_W-1:0] other;
    bit              right_len;
    other = (last_op == OP_QUERY) ? OP_INSERT : OP_QUERY;
    right_len = words_legal() && len == run_words;
    for (int p = 0; p < len; p++) begin
      op = last_op;
      if (mixed && p != len - 1 && $urandom_range(0, 1) == 1) begin
        if (!right_len)
          op = other;
        else if (last_op == OP_QUERY && query_written[p])
          op = other;
        else if (last_op == OP_INSERT &&
                 (gen_count >= MAX_SETS || slot_written[gen_count][p]))
          op = other;
      end
      if ($urandom_range(0, 29) == 0)
        send_word(OP_IGNORED, $urandom, 1'($urandom_range(0, 1)));
      send_word(op, (op == OP_QUERY) ? query_word() : set_word(), p == len - 1);
    end
  endtask

  task automatic random_items(input int count);
    int sent;
    int kind;
    int n;
    int len;
    logic [OP_W-1:0] last_op;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(0, 99);
      n = words_legal() ? int'(run_words) : $urandom_range(1, MAX_WORDS);
      last_op = $urandom_range(0, 1) ? OP_QUERY : OP_INSERT;
      if (kind < 40) begin
        send_run(OP_INSERT, n, 1'b0);
        sent += n;
      end else if (kind < 74) begin
        send_run(OP_QUERY, n, 1'b0);
        sent += n;
      end else if (kind < 85) begin
        // wrong length, including runs past the buffer size
        do len = $urandom_range(1, MAX_WORDS + 3); while (len == n);
        send_run(last_op, len, 1'b1);
        sent += len;
      end else if (kind < 94) begin
        send_run(last_op, n, 1'b1);
        sent += n;
      end else if (kind < 97) begin
        send_word(OP_CLEAR, $urandom, 1'($urandom_range(0, 1)));
        sent++;
      end else begin
        send_word(OP_IGNORED, $urandom, 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // Block is idle once every answer is back and any scan has drained
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_words_in_use(input logic [CFG_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    run_words = value;
  endtask

  // Stimulus and verdict
  initial begin : stimulus
    int cfg_seq [PHASES];
    int item_seq [PHASES];
    cfg_seq = '{4, 2, 3, 0, 7, 1, 4};
    item_seq = '{300, 250, 250, 60, 60, 250, 200};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: one-word sets, empty table, subset edge cases, full table
    write_words_in_use(3'd1);
    send_word(OP_QUERY, 32'hFFFF_FFFF, 1'b1);
    send_word(OP_INSERT, 32'hFFFF_FFFF, 1'b1);
    send_word(OP_QUERY, 32'h7FFF_FFFF, 1'b1);
    send_word(OP_QUERY, 32'hFFFF_FFFF, 1'b1);
    send_word(OP_INSERT, 32'h0000_0000, 1'b1);
    send_word(OP_QUERY, 32'h0000_0000, 1'b1);
    send_word(OP_INSERT, 32'h8000_0001, 1'b1);
    repeat (MAX_SETS - 3) send_word(OP_INSERT, $urandom & $urandom, 1'b1);
    send_word(OP_INSERT, 32'h0000_0001, 1'b1);
    // length error wins over a full table
    send_word(OP_INSERT, 32'h5555_5555, 1'b0);
    send_word(OP_INSERT, 32'hAAAA_AAAA, 1'b1);
    send_word(OP_IGNORED, 32'hFFFF_FFFF, 1'b1);
    send_word(OP_CLEAR, 32'hFFFF_FFFF, 1'b0);
    send_word(OP_QUERY, 32'h0000_0001, 1'b1);

    // Random phases over several word counts, illegal ones too
    for (int i = 0; i < PHASES; i++) begin
      settle();
      write_words_in_use(CFG_W'(cfg_seq[i]));
      send_word(OP_CLEAR, $urandom, 1'b0);
      if (i == 0) hold_request = 1'b1;
      random_items(item_seq[i]);
    end

    settle();
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/smst_pkg.sv
hdl/smst_front.sv
hdl/smst_queue.sv
hdl/smst_back.sv
hdl/subset_match_set_table.sv
tb/subset_table_checker.sv
tb/testbench.sv
